// File: rtl/bilinear_texel_filter_rgb16_top_macros.svh
// ----------------------------------------------------------------------------
// bilinear texel filter assertion macros
// shared property wrappers for the filter rtl, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXEL_FILTER_RGB16_TOP_MACROS_SVH
`define BILINEAR_TEXEL_FILTER_RGB16_TOP_MACROS_SVH

// checked outside reset only
`define BTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// types and constants shared by the bilinear texel filter pipeline
// ----------------------------------------------------------------------------
package btf_pkg;

  typedef enum logic [0:0] {
    FMT_RGB565 = 1'b0,
    FMT_RGB555 = 1'b1
  } color_fmt_e;

  typedef enum logic [0:0] {
    DEPTH_ALWAYS = 1'b0,
    DEPTH_GE     = 1'b1
  } depth_mode_e;

  // register word indexes on the config port
  localparam logic [0:0] REG_COLOR_FORMAT = 1'b0;
  localparam logic [0:0] REG_DEPTH_MODE   = 1'b1;

  // two-lane masks
  localparam logic [31:0] BLUE_MASK2      = 32'h001f_001f;
  localparam logic [31:0] GREEN_MASK2_565 = 32'h07e0_07e0;
  localparam logic [31:0] RED_MASK2_565   = 32'hf800_f800;
  localparam logic [31:0] GREEN_MASK2_555 = 32'h03e0_03e0;
  localparam logic [31:0] RED_MASK2_555   = 32'h7c00_7c00;

  // single-lane masks and rounding terms
  localparam logic [15:0] GREEN_MASK_565 = 16'h07e0;
  localparam logic [15:0] RED_MASK_565   = 16'hf800;
  localparam logic [15:0] GREEN_MASK_555 = 16'h03e0;
  localparam logic [15:0] RED_MASK_555   = 16'h7c00;
  localparam logic [31:0] ROUND_BLUE     = 32'h0000_0080;
  localparam logic [31:0] ROUND_GREEN    = 32'h0000_0100;
  localparam logic [31:0] ROUND_RED_565  = 32'h0000_0400;
  localparam logic [31:0] ROUND_RED_555  = 32'h0000_0200;

  typedef struct packed {
    color_fmt_e  color_format;
    depth_mode_e depth_mode;
  } cfg_t;

  // after setup: base and difference per channel, both lanes
  typedef struct packed {
    logic [31:0] base_b;
    logic [31:0] diff_b;
    logic [31:0] base_g;
    logic [31:0] diff_g;
    logic [31:0] base_r;
    logic [31:0] diff_r;
    logic [3:0]  frac_v;
  } setup_t;

  // after vertical blend
  typedef struct packed {
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } vert_t;

  // per-word side info that rides along the pipeline
  typedef struct packed {
    logic [15:0] texel_tl;
    logic [3:0]  frac_u;
    logic        nearest;
    logic        write_en;
  } side_t;

endpackage

// File: rtl/bilinear_texel_filter_rgb16_top.sv
// Bilinear texel filter for 16-bit RGB565/RGB555 pixels. One pixel word is
// accepted every clock while the output is not stalled, so the sustained
// rate is one word per cycle; each result passes through the three
// register stages (setup and depth test, vertical blend, horizontal blend
// into the output register). Stages advance independently: a stall on the
// output only backs up as far as the first empty stage, so new words keep
// entering while a finished result waits. Filtering follows packed two-lane
// 32-bit arithmetic with wraparound and cross-lane borrow; a failed depth
// test gives write_enable 0 and pixel 0. color_format and depth_mode sit at
// byte addresses 0 and 4 of the config port; the user must write them only
// while the pipeline is empty, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
// bilinear_texel_filter_rgb16_top
// three-stage bilinear texel filter with depth-test write enable
// ----------------------------------------------------------------------------
`include "bilinear_texel_filter_rgb16_top_macros.svh"

module bilinear_texel_filter_rgb16_top import btf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] texel_top_left_i,
  input  logic [15:0] texel_top_right_i,
  input  logic [15:0] texel_bottom_left_i,
  input  logic [15:0] texel_bottom_right_i,
  input  logic [3:0]  frac_u_i,
  input  logic [3:0]  frac_v_i,
  input  logic        nearest_i,
  input  logic [31:0] depth_new_i,
  input  logic [31:0] depth_old_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_out_o,
  output logic        write_enable_o
);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  color_fmt_e  color_format_q;
  depth_mode_e depth_mode_q;
  cfg_t        cfg;
  logic        cfg_wr;
  logic [0:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_format_q <= FMT_RGB565;
      depth_mode_q   <= DEPTH_ALWAYS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COLOR_FORMAT: color_format_q <= color_fmt_e'(pwdata[0]);
        REG_DEPTH_MODE:   depth_mode_q   <= depth_mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_COLOR_FORMAT: prdata = {31'd0, color_format_q};
      REG_DEPTH_MODE:   prdata = {31'd0, depth_mode_q};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.color_format = color_format_q;
  assign cfg.depth_mode   = depth_mode_q;

  // --------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_en, s2_en, out_en;

  assign out_en     = !out_v_q || !out_stall_i;
  assign s2_en      = !s2_v_q || out_en;
  assign s1_en      = !s1_v_q || s2_en;
  assign in_stall_o = !s1_en;

  // --------------------------------------------------------------------------
  // stage 1: setup and depth test
  // --------------------------------------------------------------------------
  setup_t setup_d, s1_q;
  side_t  side_d, s1_side_q;
  logic   write_en_d;

  btf_setup u_setup (
    .cfg_i                (cfg),
    .texel_top_left_i     (texel_top_left_i),
    .texel_top_right_i    (texel_top_right_i),
    .texel_bottom_left_i  (texel_bottom_left_i),
    .texel_bottom_right_i (texel_bottom_right_i),
    .frac_v_i             (frac_v_i),
    .depth_new_i          (depth_new_i),
    .depth_old_i          (depth_old_i),
    .setup_o              (setup_d),
    .write_en_o           (write_en_d)
  );

  always_comb begin
    side_d.texel_tl = texel_top_left_i;
    side_d.frac_u   = frac_u_i;
    side_d.nearest  = nearest_i;
    side_d.write_en = write_en_d;
  end

  // --------------------------------------------------------------------------
  // stage 2: vertical blend
  // --------------------------------------------------------------------------
  vert_t vert_d, s2_q;
  side_t s2_side_q;

  btf_vert_blend u_vert (
    .setup_i (s1_q),
    .vert_o  (vert_d)
  );

  // --------------------------------------------------------------------------
  // stage 3: horizontal blend into the output register
  // --------------------------------------------------------------------------
  logic [15:0] pixel_d, pixel_q;
  logic        we_q;

  btf_horz_blend u_horz (
    .cfg_i   (cfg),
    .vert_i  (s2_q),
    .side_i  (s2_side_q),
    .pixel_o (pixel_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en)  s1_v_q  <= in_valid_i;
      if (s2_en)  s2_v_q  <= s1_v_q;
      if (out_en) out_v_q <= s2_v_q;
    end
  end

  // payload, loaded only with a valid word
  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_q      <= setup_d;
      s1_side_q <= side_d;
    end
    if (s2_en && s1_v_q) begin
      s2_q      <= vert_d;
      s2_side_q <= s1_side_q;
    end
    if (out_en && s2_v_q) begin
      pixel_q <= pixel_d;
      we_q    <= s2_side_q.write_en;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pixel_out_o    = pixel_q;
  assign write_enable_o = we_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `BTF_ASSERT(a_stage2_held, (s2_v_q && out_v_q && out_stall_i) |=> s2_v_q, "stage 2 word dropped under stall")
  `BTF_ASSERT(a_stall_only_full, in_stall_o |-> (s1_v_q && s2_v_q && out_v_q && out_stall_i), "input stalled with room in the pipeline")
  `BTF_ASSERT(a_masked_pixel_zero, (out_valid_o && !write_enable_o) |-> (pixel_out_o == 16'd0), "masked write carries a nonzero pixel")
  `BTF_ASSERT(a_always_write, (out_valid_o && (depth_mode_q == DEPTH_ALWAYS)) |-> write_enable_o, "write enable low with depth test off")
  `BTF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule

// File: rtl/btf_setup.sv
// ----------------------------------------------------------------------------
// btf_setup
// lane packing, channel masking, vertical differences and depth test
// ----------------------------------------------------------------------------
module btf_setup import btf_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [15:0] texel_top_left_i,
  input  logic [15:0] texel_top_right_i,
  input  logic [15:0] texel_bottom_left_i,
  input  logic [15:0] texel_bottom_right_i,
  input  logic [3:0]  frac_v_i,
  input  logic [31:0] depth_new_i,
  input  logic [31:0] depth_old_i,
  output setup_t      setup_o,
  output logic        write_en_o
);

  logic [31:0] top_w;
  logic [31:0] bot_w;
  logic [31:0] gmask;
  logic [31:0] rmask;
  logic [31:0] top_r;
  logic [31:0] bot_r;

  // left texel in the low lane
  assign top_w = {texel_top_right_i, texel_top_left_i};
  assign bot_w = {texel_bottom_right_i, texel_bottom_left_i};

  always_comb begin
    unique case (cfg_i.color_format)
      FMT_RGB555: begin
        gmask = GREEN_MASK2_555;
        rmask = RED_MASK2_555;
      end
      default: begin
        gmask = GREEN_MASK2_565;
        rmask = RED_MASK2_565;
      end
    endcase
  end

  assign top_r = (top_w & rmask) >> 8;
  assign bot_r = (bot_w & rmask) >> 8;

  always_comb begin
    setup_o.base_b = top_w & BLUE_MASK2;
    setup_o.diff_b = (bot_w & BLUE_MASK2) - (top_w & BLUE_MASK2);
    setup_o.base_g = top_w & gmask;
    setup_o.diff_g = (bot_w & gmask) - (top_w & gmask);
    setup_o.base_r = top_r;
    setup_o.diff_r = bot_r - top_r;
    setup_o.frac_v = frac_v_i;
  end

  assign write_en_o = !((cfg_i.depth_mode == DEPTH_GE) && (depth_new_i < depth_old_i));

endmodule

// File: rtl/btf_vert_blend.sv
// ----------------------------------------------------------------------------
// btf_vert_blend
// vertical blend of both lanes by frac_v, modulo 2^32
// ----------------------------------------------------------------------------
module btf_vert_blend import btf_pkg::*; (
  input  setup_t setup_i,
  output vert_t  vert_o
);

  logic [31:0] fv_ext;
  logic [31:0] prod_b;
  logic [31:0] prod_g;
  logic [31:0] prod_r;
  logic [31:0] green_sra;

  assign fv_ext = {28'd0, setup_i.frac_v};
  assign prod_b = fv_ext * setup_i.diff_b;
  assign prod_g = fv_ext * setup_i.diff_g;
  assign prod_r = fv_ext * setup_i.diff_r;

  // green term shifts as a signed word
  assign green_sra = 32'($signed(prod_g) >>> 4);

  always_comb begin
    vert_o.blue  = (setup_i.base_b << 4) + prod_b;
    vert_o.green = setup_i.base_g + green_sra;
    vert_o.red   = (setup_i.base_r << 4) + prod_r;
  end

endmodule

// File: rtl/btf_horz_blend.sv
// ----------------------------------------------------------------------------
// btf_horz_blend
// horizontal blend of left lane toward right lane, pack and final select
// ----------------------------------------------------------------------------
module btf_horz_blend import btf_pkg::*; (
  input  cfg_t        cfg_i,
  input  vert_t       vert_i,
  input  side_t       side_i,
  output logic [15:0] pixel_o
);

  logic [31:0] fu_ext;
  logic [31:0] b_lo, b_hi, g_lo, g_hi, r_lo, r_hi;
  logic [31:0] b_sum, g_step, r_sum;
  logic [31:0] b_ch, g_ch, r_ch;
  logic [31:0] packed_w;
  logic [15:0] gmask16;
  logic [15:0] rmask16;
  logic [31:0] rround;

  always_comb begin
    unique case (cfg_i.color_format)
      FMT_RGB555: begin
        gmask16 = GREEN_MASK_555;
        rmask16 = RED_MASK_555;
        rround  = ROUND_RED_555;
      end
      default: begin
        gmask16 = GREEN_MASK_565;
        rmask16 = RED_MASK_565;
        rround  = ROUND_RED_565;
      end
    endcase
  end

  assign fu_ext = {28'd0, side_i.frac_u};

  assign b_lo = {16'd0, vert_i.blue[15:0]};
  assign b_hi = {16'd0, vert_i.blue[31:16]};
  assign g_lo = {16'd0, vert_i.green[15:0]};
  assign g_hi = {16'd0, vert_i.green[31:16]};
  assign r_lo = {16'd0, vert_i.red[15:0]};
  assign r_hi = {16'd0, vert_i.red[31:16]};

  assign b_sum  = (b_lo << 4) + fu_ext * (b_hi - b_lo) + ROUND_BLUE;
  assign g_step = (fu_ext * (g_hi - g_lo) + ROUND_GREEN) >> 4;
  assign r_sum  = (r_lo << 4) + fu_ext * (r_hi - r_lo) + rround;

  assign b_ch = b_sum >> 8;
  assign g_ch = (g_lo + g_step) & {16'd0, gmask16};
  assign r_ch = r_sum & {16'd0, rmask16};

  // stray high blue bits may land in green or red
  assign packed_w = r_ch | g_ch | b_ch;

  always_comb begin
    priority if (!side_i.write_en) begin
      pixel_o = 16'd0;
    end else if (side_i.nearest) begin
      pixel_o = side_i.texel_tl;
    end else begin
      pixel_o = packed_w[15:0];
    end
  end

endmodule
